/* hw/rtl/timed_task_dispatcher_defines.svh */
// Assertion macros used by the dispatcher datapath.
// Expects signals clk and rst_n in the scope of each use.
`ifndef TIMED_TASK_DISPATCHER_DEFINES_SVH
`define TIMED_TASK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ttd_pkg.sv */
// Shared types and constants for the timed task dispatcher.
// No dependencies; imported by the controller, datapath and top level.
package ttd_pkg;

  // Action codes carried by an input beat
  typedef enum logic [3:0] {
    ACT_TICK     = 4'd0,
    ACT_CREATE   = 4'd1,
    ACT_DELETE   = 4'd2,
    ACT_START    = 4'd3,
    ACT_DELAY    = 4'd4,
    ACT_STOP     = 4'd5,
    ACT_DISPATCH = 4'd6,
    ACT_FINISH   = 4'd7,
    ACT_CLR_UP   = 4'd8
  } action_t;

  // Per-slot enable state
  typedef enum logic [1:0] {
    TS_STOPPED = 2'd0,
    TS_ENABLED = 2'd1,
    TS_RUNNING = 2'd2
  } tstate_t;

  localparam logic [31:0] UNSET_DUE  = 32'hFFFF_FFFF;
  localparam logic [9:0]  MS_PER_SEC = 10'd1000;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted input beat
    logic rd;         // read slot at idx into the pipeline register
    logic inc;        // advance the scan index
    logic idx_clr;    // restart the scan at slot zero
    logic idx_home;   // point the index back at the addressed slot
    logic tick_base;  // advance time base and uptime
    logic tick_slot;  // rebase and ready-check one slot
    logic exec;       // apply a single-slot action or uptime clear
    logic late;       // compute lateness of the selected slot
    logic commit;     // retire the dispatched slot, update worst latency
    logic emit;       // load the result register
  } ttd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    action_t act;
    logic    hit;       // slot in the pipeline is ready and enabled
    logic    p_last;    // slot in the pipeline is the last one
    logic    out_busy;  // result register holds a beat not taken this cycle
  } ttd_sts_t;

endpackage

/* hw/rtl/ttd_if.sv */
// Valid/ready channel interfaces for the dispatcher input and result beats.
// No dependencies.
interface ttd_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [3:0]  task_id;
  logic [30:0] delay_ms;
  logic        handler_valid;

  modport source (output valid, action, task_id, delay_ms, handler_valid, input ready);
  modport sink   (input valid, action, task_id, delay_ms, handler_valid, output ready);
endinterface

interface ttd_out_if;
  logic        valid;
  logic        ready;
  logic        dispatched;
  logic [3:0]  dispatched_id;
  logic        handler_present;
  logic [1:0]  task_state;
  logic [7:0]  task_count;
  logic [31:0] max_latency;
  logic [22:0] uptime_seconds;

  modport source (output valid, dispatched, dispatched_id, handler_present, task_state,
                  task_count, max_latency, uptime_seconds, input ready);
  modport sink   (input valid, dispatched, dispatched_id, handler_present, task_state,
                  task_count, max_latency, uptime_seconds, output ready);
endinterface

/* hw/rtl/ttd_ctrl.sv */
// Sequencing state machine of the timed task dispatcher.
// Depends on ttd_pkg for the command and status structs.
module ttd_ctrl
  import ttd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ttd_sts_t sts,
  output ttd_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_PRIME,
    ST_TSCAN,
    ST_DSCAN,
    ST_LATE,
    ST_MAXL,
    ST_SETTLE,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Decode next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.act)
          ACT_TICK: begin
            cmd.tick_base = 1'b1;
            cmd.idx_clr   = 1'b1;
            state_nxt     = ST_PRIME;
          end
          ACT_DISPATCH: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = ST_PRIME;
          end
          default: begin
            cmd.exec  = 1'b1;
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_PRIME: begin
        cmd.rd    = 1'b1;
        cmd.inc   = 1'b1;
        state_nxt = (sts.act == ACT_TICK) ? ST_TSCAN : ST_DSCAN;
      end
      ST_TSCAN: begin
        cmd.tick_slot = 1'b1;
        if (sts.p_last) begin
          cmd.idx_home = 1'b1;
          state_nxt    = ST_SETTLE;
        end else begin
          cmd.rd  = 1'b1;
          cmd.inc = 1'b1;
        end
      end
      ST_DSCAN: begin
        if (sts.hit) begin
          state_nxt = ST_LATE;
        end else if (sts.p_last) begin
          cmd.idx_home = 1'b1;
          state_nxt    = ST_SETTLE;
        end else begin
          cmd.rd  = 1'b1;
          cmd.inc = 1'b1;
        end
      end
      ST_LATE: begin
        cmd.late  = 1'b1;
        state_nxt = ST_MAXL;
      end
      ST_MAXL: begin
        cmd.commit   = 1'b1;
        cmd.idx_home = 1'b1;
        state_nxt    = ST_SETTLE;
      end
      ST_SETTLE: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/ttd_datapath.sv */
// Task table, time base, counters and result register of the dispatcher.
// Depends on ttd_pkg, ttd_if and the assertion macros header.
`include "timed_task_dispatcher_defines.svh"

module ttd_datapath
  import ttd_pkg::*;
#(
  parameter int          NUM_TASKS   = 16,
  parameter logic [31:0] REBASE_TIME = 32'h8000_0000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ttd_cmd_t    cmd,
  output ttd_sts_t    sts,
  input  logic [3:0]  in_action,
  input  logic [3:0]  in_task_id,
  input  logic [30:0] in_delay_ms,
  input  logic        in_handler_valid,
  ttd_out_if.source   out_ch
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  // Captured input beat
  action_t           act_r;
  logic [IDX_W-1:0]  tidx_r;
  logic              tvalid_r;
  logic [30:0]       delay_r;
  logic              hv_r;

  // Slot table
  logic [31:0]           due_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]  vld_r;
  logic [NUM_TASKS-1:0]  ready_r;
  logic [NUM_TASKS-1:0]  hh_r;
  tstate_t               state_r [NUM_TASKS];

  // Scan index and read pipeline
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  pidx_r;
  logic [31:0]       due_q_r;

  // Time base and counters
  logic [31:0]  st_r;
  logic         rebase_r;
  logic [31:0]  up_r;
  logic [9:0]   ms_r;
  logic [22:0]  sec_r;
  logic [31:0]  worst_r;
  logic [31:0]  late_r;
  logic [7:0]   cnt_r;

  // Dispatch result
  logic        disp_r;
  logic [3:0]  did_r;
  logic        hp_r;

  // Result register
  logic        ov_r;
  logic        o_disp_r;
  logic [3:0]  o_did_r;
  logic        o_hp_r;
  logic [1:0]  o_ts_r;
  logic [7:0]  o_cnt_r;
  logic [31:0] o_lat_r;
  logic [22:0] o_sec_r;

  logic [31:0]  due_eff;
  logic [31:0]  cmp_val;
  logic [31:0]  rebased;
  logic [31:0]  due_sum;
  logic [32:0]  late_diff;
  logic         slot_ready;
  logic         due_we;
  logic [31:0]  due_wdata;
  tstate_t      p_state;

  assign p_state    = state_r[pidx_r];
  assign due_eff    = vld_r[pidx_r] ? due_q_r : UNSET_DUE;
  assign cmp_val    = rebase_r ? REBASE_TIME : st_r;
  assign rebased    = (due_q_r >= REBASE_TIME) ? (due_q_r - REBASE_TIME) : 32'd0;
  assign due_sum    = {1'b0, delay_r} + st_r;
  assign late_diff  = {1'b0, st_r} - {1'b0, due_eff};
  assign slot_ready = (p_state == TS_ENABLED) && (due_eff <= cmp_val);

  // Status to the controller
  assign sts.act      = act_r;
  assign sts.hit      = ready_r[pidx_r] && (p_state == TS_ENABLED);
  assign sts.p_last   = (pidx_r == LAST_IDX);
  assign sts.out_busy = ov_r && !out_ch.ready;

  // Due-time write port: rebase on tick, load on start or re-delay
  always_comb begin
    due_we    = 1'b0;
    due_wdata = due_sum;
    if (cmd.tick_slot && rebase_r && (due_eff != UNSET_DUE)) begin
      due_we    = 1'b1;
      due_wdata = rebased;
    end else if (cmd.exec && tvalid_r && (act_r == ACT_START || act_r == ACT_DELAY)) begin
      due_we = 1'b1;
    end
  end

  // Due-time memory and registered read
  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[pidx_r] <= due_wdata;
    end
    if (cmd.rd) begin
      due_q_r <= due_mem[idx_r];
      pidx_r  <= idx_r;
    end
  end

  // Capture the input beat and late value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= action_t'(in_action);
      tidx_r   <= IDX_W'(in_task_id);
      tvalid_r <= (7'(in_task_id) < 7'(NUM_TASKS));
      delay_r  <= in_delay_ms;
      hv_r     <= in_handler_valid;
    end
    if (cmd.late) begin
      late_r <= late_diff[32] ? 32'd0 : late_diff[31:0];
    end
  end

  // Control state: table flags, index, time base, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      ready_r  <= '0;
      hh_r     <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        state_r[i] <= TS_STOPPED;
      end
      idx_r    <= '0;
      st_r     <= '0;
      rebase_r <= 1'b0;
      up_r     <= '0;
      ms_r     <= '0;
      sec_r    <= '0;
      worst_r  <= '0;
      cnt_r    <= '0;
      disp_r   <= 1'b0;
      did_r    <= '0;
      hp_r     <= 1'b0;
    end else begin
      // load, clear, home or advance the scan index, saturating at the last slot
      if (cmd.load) begin
        idx_r <= IDX_W'(in_task_id);
      end else if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_home) begin
        idx_r <= tidx_r;
      end else if (cmd.inc && idx_r != LAST_IDX) begin
        idx_r <= idx_r + IDX_W'(1);
      end

      if (cmd.load) begin
        disp_r <= 1'b0;
        did_r  <= '0;
        hp_r   <= 1'b0;
      end

      // tick: advance time base, wrap uptime, keep seconds in step
      if (cmd.tick_base) begin
        rebase_r <= (st_r == REBASE_TIME - 32'd1);
        st_r     <= (st_r == REBASE_TIME - 32'd1) ? 32'd0 : st_r + 32'd1;
        if (up_r == 32'hFFFF_FFFF) begin
          up_r  <= '0;
          ms_r  <= '0;
          sec_r <= '0;
        end else begin
          up_r <= up_r + 32'd1;
          if (ms_r == MS_PER_SEC - 10'd1) begin
            ms_r  <= '0;
            sec_r <= sec_r + 23'd1;
          end else begin
            ms_r <= ms_r + 10'd1;
          end
        end
      end

      // tick: mark due slots ready
      if (cmd.tick_slot && slot_ready) begin
        ready_r[pidx_r] <= 1'b1;
      end

      // single-slot actions
      if (cmd.exec) begin
        if (act_r == ACT_CLR_UP) begin
          up_r  <= '0;
          ms_r  <= '0;
          sec_r <= '0;
        end
        if (tvalid_r) begin
          case (act_r)
            ACT_CREATE: begin
              hh_r[pidx_r] <= hv_r;
              cnt_r        <= cnt_r + 8'd1;
            end
            ACT_DELETE: begin
              state_r[pidx_r] <= TS_STOPPED;
              vld_r[pidx_r]   <= 1'b0;
              ready_r[pidx_r] <= 1'b0;
              hh_r[pidx_r]    <= 1'b0;
              cnt_r           <= cnt_r - 8'd1;
            end
            ACT_START: begin
              vld_r[pidx_r]   <= 1'b1;
              state_r[pidx_r] <= TS_ENABLED;
              ready_r[pidx_r] <= (delay_r == 31'd0);
            end
            ACT_DELAY: begin
              vld_r[pidx_r] <= 1'b1;
            end
            ACT_STOP: begin
              state_r[pidx_r] <= TS_STOPPED;
              vld_r[pidx_r]   <= 1'b0;
              ready_r[pidx_r] <= 1'b0;
            end
            ACT_FINISH: begin
              if (p_state == TS_RUNNING) begin
                state_r[pidx_r] <= (due_eff == UNSET_DUE) ? TS_STOPPED : TS_ENABLED;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // retire the dispatched slot and track worst lateness
      if (cmd.commit) begin
        if (late_r > worst_r) begin
          worst_r <= late_r;
        end
        vld_r[pidx_r]   <= 1'b0;
        ready_r[pidx_r] <= 1'b0;
        state_r[pidx_r] <= hh_r[pidx_r] ? TS_RUNNING : TS_STOPPED;
        disp_r          <= 1'b1;
        did_r           <= 4'(pidx_r);
        hp_r            <= hh_r[pidx_r];
      end
    end
  end

  // Result register: load on emit, drop on handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_disp_r <= disp_r;
      o_did_r  <= did_r;
      o_hp_r   <= hp_r;
      o_ts_r   <= tvalid_r ? p_state : TS_STOPPED;
      o_cnt_r  <= cnt_r;
      o_lat_r  <= worst_r;
      o_sec_r  <= sec_r;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.dispatched      = o_disp_r;
  assign out_ch.dispatched_id   = o_did_r;
  assign out_ch.handler_present = o_hp_r;
  assign out_ch.task_state      = o_ts_r;
  assign out_ch.task_count      = o_cnt_r;
  assign out_ch.max_latency     = o_lat_r;
  assign out_ch.uptime_seconds  = o_sec_r;

  `TTD_ASSERT_NOW(a_time_below_rebase, 1'b1, st_r < REBASE_TIME, "time base reached rebase point")
  `TTD_ASSERT_NOW(a_ms_in_range, 1'b1, ms_r < MS_PER_SEC, "millisecond remainder out of range")
  `TTD_ASSERT_NEXT(a_worst_monotonic, 1'b1, worst_r >= $past(worst_r), "worst latency decreased")
  `TTD_ASSERT_NEXT(a_commit_marks, cmd.commit, disp_r && !ready_r[$past(pidx_r)], "dispatch not retired")

endmodule

/* hw/rtl/timed_task_dispatcher.sv */
// Top level of the timed task dispatcher: controller plus datapath.
// Depends on ttd_pkg, ttd_if, ttd_ctrl and ttd_datapath.
//
//  channel | direction | beat contents
//  --------+-----------+--------------------------------------------------------
//  in_ch   | in        | action, task_id, delay_ms, handler_valid
//  out_ch  | out       | dispatched, dispatched_id, handler_present, task_state,
//          |           | task_count, max_latency, uptime_seconds
//
// One item at a time. A slot action is fetched, executed and then emitted; a tick
// makes one pass over the due-time memory, one slot per cycle, and a dispatch scans
// for the lowest ready slot, then runs the lateness subtract and compare steps.
// Reset is synchronous; due times read as unset through per-slot valid bits, so
// no clearing pass is needed.
// A stalled result holds in the output register; the next beat is taken meanwhile.
module timed_task_dispatcher
  import ttd_pkg::*;
#(
  parameter int          NUM_TASKS   = 16,
  parameter logic [31:0] REBASE_TIME = 32'h8000_0000
) (
  input  logic       clk,
  input  logic       rst_n,
  ttd_in_if.sink     in_ch,
  ttd_out_if.source  out_ch
);

  ttd_cmd_t cmd;
  ttd_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  ttd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttd_datapath #(
    .NUM_TASKS   (NUM_TASKS),
    .REBASE_TIME (REBASE_TIME)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_task_id       (in_ch.task_id),
    .in_delay_ms      (in_ch.delay_ms),
    .in_handler_valid (in_ch.handler_valid),
    .out_ch           (out_ch)
  );

endmodule

/* dv/timed_task_dispatcher_tb.sv */
// Self-checking testbench for timed_task_dispatcher: directed and random task-table actions.
// Depends on ttd_pkg, ttd_if and the dispatcher RTL; expected results are computed in-line.
`timescale 1ns / 1ps

module timed_task_dispatcher_tb;
  import ttd_pkg::*;

  localparam int          NUM_SLOTS      = 16;
  localparam logic [31:0] REBASE_AT      = 32'h8000_0000;
  localparam logic [3:0]  ACT_UNUSED_LO  = 4'd9;
  localparam logic [3:0]  ACT_UNUSED_HI  = 4'd15;
  localparam int          RANDOM_ITEMS   = 470;
  localparam int          QUIET_TAIL     = 60;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [3:0]  action;
    logic [3:0]  task_id;
    logic [30:0] delay_ms;
    logic        handler_valid;
    bit          drain_first;
  } cmd_beat_t;

  typedef struct {
    logic        dispatched;
    logic [3:0]  dispatched_id;
    logic        handler_present;
    logic [1:0]  task_state;
    logic [7:0]  task_count;
    logic [31:0] max_latency;
    logic [22:0] uptime_seconds;
  } status_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  ttd_in_if  in_ch ();
  ttd_out_if out_ch ();

  timed_task_dispatcher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Scheduler image kept by the testbench
  tstate_t     slot_state [NUM_SLOTS];
  logic [31:0] slot_due   [NUM_SLOTS];
  bit          slot_ready [NUM_SLOTS];
  bit          slot_hndl  [NUM_SLOTS];
  logic [31:0] sys_time;
  logic [31:0] up_ticks;
  logic [31:0] worst_late;
  logic [7:0]  live_tasks;

  cmd_beat_t    pend_q [$];
  status_beat_t status_q [$];
  int           errors;
  int           total_items;
  int           accepted_n;
  int           counted_items;
  int           in_gap;
  int           out_gap;
  int           quiet_cycles;
  bit           in_fire;
  bit           calm;

  function automatic void vacate_slot(int id);
    slot_state[id] = TS_STOPPED;
    slot_due[id]   = UNSET_DUE;
    slot_ready[id] = 1'b0;
  endfunction

  function automatic void sched_reset();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      vacate_slot(i);
      slot_hndl[i] = 1'b0;
    end
    sys_time   = '0;
    up_ticks   = '0;
    worst_late = '0;
    live_tasks = '0;
  endfunction

  // Apply one action to the image and return the status beat it produces
  function automatic status_beat_t schedule_step(cmd_beat_t c);
    status_beat_t r;
    int           id;
    bit           found;
    logic [31:0]  late;
    id    = c.task_id;
    found = 1'b0;
    r.dispatched      = 1'b0;
    r.dispatched_id   = '0;
    r.handler_present = 1'b0;
    case (c.action)
      ACT_TICK: begin
        sys_time = sys_time + 32'd1;
        up_ticks = up_ticks + 32'd1;
        // rebase the time base and every set due time, saturating at zero
        if (sys_time >= REBASE_AT) begin
          for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_due[i] != UNSET_DUE)
              slot_due[i] = (slot_due[i] >= REBASE_AT) ? slot_due[i] - REBASE_AT : '0;
          sys_time = sys_time - REBASE_AT;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_state[i] == TS_ENABLED && slot_due[i] <= sys_time)
            slot_ready[i] = 1'b1;
      end
      ACT_CREATE: begin
        slot_hndl[id] = c.handler_valid;
        live_tasks    = live_tasks + 8'd1;
      end
      ACT_DELETE: begin
        vacate_slot(id);
        slot_hndl[id] = 1'b0;
        live_tasks    = live_tasks - 8'd1;
      end
      ACT_START: begin
        slot_due[id]   = {1'b0, c.delay_ms} + sys_time;
        slot_state[id] = TS_ENABLED;
        slot_ready[id] = (c.delay_ms == '0);
      end
      ACT_DELAY: slot_due[id] = {1'b0, c.delay_ms} + sys_time;
      ACT_STOP:  vacate_slot(id);
      ACT_DISPATCH: begin
        // pick the lowest ready and enabled slot, track its lateness
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && slot_ready[i] && slot_state[i] == TS_ENABLED) begin
            found = 1'b1;
            late  = (sys_time > slot_due[i]) ? sys_time - slot_due[i] : '0;
            if (late > worst_late)
              worst_late = late;
            slot_due[i]   = UNSET_DUE;
            slot_ready[i] = 1'b0;
            slot_state[i] = slot_hndl[i] ? TS_RUNNING : TS_STOPPED;
            r.dispatched      = 1'b1;
            r.dispatched_id   = i[3:0];
            r.handler_present = slot_hndl[i];
          end
        end
      end
      ACT_FINISH: begin
        if (slot_state[id] == TS_RUNNING)
          slot_state[id] = (slot_due[id] == UNSET_DUE) ? TS_STOPPED : TS_ENABLED;
      end
      ACT_CLR_UP: up_ticks = '0;
      default: ;
    endcase
    r.task_state     = slot_state[id];
    r.task_count     = live_tasks;
    r.max_latency    = worst_late;
    r.uptime_seconds = 23'(up_ticks / 32'd1000);
    return r;
  endfunction

  task automatic push_beat(logic [3:0] act, logic [3:0] id, logic [30:0] dly, logic hv,
                           bit drain = 1'b0);
    cmd_beat_t c;
    c.action        = act;
    c.task_id       = id;
    c.delay_ms      = dly;
    c.handler_valid = hv;
    c.drain_first   = drain;
    pend_q.push_back(c);
    if (act <= ACT_CLR_UP)
      counted_items++;
  endtask

  // One task lifetime: maybe create, arm, let time pass, dispatch, maybe re-arm and finish, maybe stop or delete
  task automatic push_episode();
    logic [3:0]  s;
    logic [30:0] d;
    int          n;
    s = 4'($urandom_range(0, NUM_SLOTS - 1));
    d = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 6));
    n = $urandom_range(0, 8);
    if ($urandom_range(0, 2) != 0)
      push_beat(ACT_CREATE, s, 31'($urandom), $urandom_range(0, 3) != 0);
    push_beat(ACT_START, s, d, 1'($urandom));
    repeat (n) push_beat(ACT_TICK, 4'($urandom), 31'($urandom), 1'($urandom));
    repeat ($urandom_range(1, 2)) push_beat(ACT_DISPATCH, s, 31'($urandom), 1'($urandom));
    if ($urandom_range(0, 1) == 0)
      push_beat(ACT_DELAY, s, 31'($urandom_range(0, 5)), 1'($urandom));
    if ($urandom_range(0, 2) != 0)
      push_beat(ACT_FINISH, s, 31'($urandom), 1'($urandom));
    case ($urandom_range(0, 5))
      0:       push_beat(ACT_STOP, s, 31'($urandom), 1'($urandom));
      1:       push_beat(ACT_DELETE, s, 31'($urandom), 1'($urandom));
      default: ;
    endcase
  endtask

  // Drive input beats at the falling edge; hold a beat until it is taken
  always @(negedge clk) begin
    cmd_beat_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold
    end else if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (pend_q.size() == 0 || (pend_q[0].drain_first && status_q.size() != 0)) begin
      in_ch.valid <= 1'b0;
    end else begin
      c = pend_q.pop_front();
      in_ch.action        <= c.action;
      in_ch.task_id       <= c.task_id;
      in_ch.delay_ms      <= c.delay_ms;
      in_ch.handler_valid <= c.handler_valid;
      in_ch.valid         <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0)
        in_gap = $urandom_range(1, 14);
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap = out_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      out_gap = $urandom_range(0, 13);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Capture accepted input beats and queue their predicted status
  always @(posedge clk) begin
    cmd_beat_t c;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        c.action        = in_ch.action;
        c.task_id       = in_ch.task_id;
        c.delay_ms      = in_ch.delay_ms;
        c.handler_valid = in_ch.handler_valid;
        c.drain_first   = 1'b0;
        status_q.push_back(schedule_step(c));
        accepted_n = accepted_n + 1;
        calm <= (accepted_n >= total_items - QUIET_TAIL);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    status_beat_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: result beat with no prediction pending, actual count %0h latency %0h",
                 $time, out_ch.task_count, out_ch.max_latency);
        errors++;
      end else begin
        w = status_q.pop_front();
        check_field("dispatched", 32'(w.dispatched), 32'(out_ch.dispatched));
        check_field("dispatched_id", 32'(w.dispatched_id), 32'(out_ch.dispatched_id));
        check_field("handler_present", 32'(w.handler_present), 32'(out_ch.handler_present));
        check_field("task_state", 32'(w.task_state), 32'(out_ch.task_state));
        check_field("task_count", 32'(w.task_count), 32'(out_ch.task_count));
        check_field("max_latency", w.max_latency, out_ch.max_latency);
        check_field("uptime_seconds", 32'(w.uptime_seconds), 32'(out_ch.uptime_seconds));
      end
    end
  end

  // Abort when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int base;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_TICK;
    in_ch.task_id        = '0;
    in_ch.delay_ms       = '0;
    in_ch.handler_valid  = 1'b0;
    out_ch.ready         = 1'b0;
    errors        = 0;
    accepted_n    = 0;
    counted_items = 0;
    in_gap        = 0;
    out_gap       = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    sched_reset();

    // Directed: empty table, zero delay, lateness, re-arm on finish, count wrap
    push_beat(ACT_TICK, 4'd0, '0, 1'b0);
    push_beat(ACT_DISPATCH, 4'd0, '0, 1'b0);
    push_beat(ACT_CREATE, 4'd0, '0, 1'b1);
    push_beat(ACT_CREATE, 4'd15, '0, 1'b0);
    push_beat(ACT_START, 4'd15, '0, 1'b0);
    push_beat(ACT_START, 4'd0, 31'd2, 1'b0);
    push_beat(ACT_DISPATCH, 4'd15, '0, 1'b0);
    repeat (3) push_beat(ACT_TICK, 4'd0, '0, 1'b0);
    push_beat(ACT_DISPATCH, 4'd0, '0, 1'b0);
    push_beat(ACT_FINISH, 4'd0, '0, 1'b0);
    push_beat(ACT_START, 4'd0, '0, 1'b0);
    push_beat(ACT_DISPATCH, 4'd0, '0, 1'b0);
    push_beat(ACT_DELAY, 4'd0, 31'h7FFF_FFFF, 1'b0);
    push_beat(ACT_FINISH, 4'd0, '0, 1'b0);
    push_beat(ACT_STOP, 4'd0, '0, 1'b0);
    push_beat(ACT_FINISH, 4'd0, '0, 1'b0);
    push_beat(ACT_DELETE, 4'd3, '0, 1'b0);
    push_beat(ACT_DELETE, 4'd4, '0, 1'b0);
    push_beat(ACT_DELETE, 4'd5, '0, 1'b0);
    push_beat(ACT_UNUSED_LO, 4'd15, 31'h7FFF_FFFF, 1'b1);
    push_beat(ACT_UNUSED_HI, 4'd0, '0, 1'b0);
    push_beat(ACT_CLR_UP, 4'd7, '0, 1'b0);
    push_beat(ACT_CREATE, 4'd15, 31'h7FFF_FFFF, 1'b1);
    push_beat(ACT_START, 4'd7, 31'h7FFF_FFFF, 1'b1);

    // Random: mostly task lifetimes, some noise; wait for an empty pipeline at the start and midway
    base = counted_items;
    push_beat(ACT_CLR_UP, 4'($urandom), 31'($urandom), 1'($urandom), 1'b1);
    while (counted_items - base < RANDOM_ITEMS) begin
      if (counted_items - base >= RANDOM_ITEMS / 2 && counted_items - base < RANDOM_ITEMS / 2 + 8)
        push_beat(ACT_DISPATCH, 4'($urandom), 31'($urandom), 1'($urandom), 1'b1);
      if ($urandom_range(0, 9) < 7)
        push_episode();
      else
        push_beat(4'($urandom), 4'($urandom), 31'($urandom), 1'($urandom));
    end
    total_items = pend_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for all beats to be taken, all results to arrive, then settle
    while (accepted_n < total_items) @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
